/* design/plucked_string_synth_core_defines.svh */
// Assertion macros for the checker file of the plucked string core.
`ifndef PLUCKED_STRING_SYNTH_CORE_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss assertion failed");

`endif

/* design/pss_pkg.sv */
package pss_pkg;

    localparam int DELAY_BITS  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 32;
    localparam int GAIN_BITS   = 16;
    localparam int FRAC_BITS   = PHASE_BITS - DELAY_BITS;
    localparam int LINE_SIZE   = 1 << DELAY_BITS;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = PHASE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_GAIN = CFG_INDEX_BITS'(1);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PLUCK = 1'b1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1 << (GAIN_BITS - 1));
    localparam logic [DELAY_BITS-1:0] LAST_ADDR = {DELAY_BITS{1'b1}};

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] WIDE_MAX = SUM_BITS'(S_MAX);
    localparam logic signed [SUM_BITS-1:0] WIDE_MIN = SUM_BITS'(S_MIN);
    localparam logic signed [SUM_BITS-1:0] WIDE_ONE = -WIDE_MIN;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DELAY_BITS-1:0] line_addr_t;

    // One write into the delay line.
    typedef struct packed {
        logic       en;
        line_addr_t addr;
        sample_t    data;
    } line_wr_t;

    function automatic sample_t sat_sample(input logic signed [SUM_BITS-1:0] v);
        sample_t r;
        if (v > WIDE_MAX)
        begin
            r = S_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r = S_MIN;
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* design/pss_line_ram.sv */
// Delay line store: two registered read ports, one write port. A per-entry
// valid flag, cleared by reset, makes untouched entries read as silence.
module pss_line_ram
    import pss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  line_addr_t rd_addr0,
    input  line_addr_t rd_addr1,
    input  line_wr_t   wr,
    output sample_t    rd_data0,
    output sample_t    rd_data1
);

    sample_t                mem [LINE_SIZE];
    logic [LINE_SIZE-1:0]   valid_reg;
    sample_t                data0_reg;
    sample_t                data1_reg;
    logic                   hit0_reg;
    logic                   hit1_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        data0_reg <= mem[rd_addr0];
        data1_reg <= mem[rd_addr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit0_reg  <= 1'b0;
            hit1_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit0_reg <= valid_reg[rd_addr0];
            hit1_reg <= valid_reg[rd_addr1];
        end
    end

    assign rd_data0 = hit0_reg ? data0_reg : '0;
    assign rd_data1 = hit1_reg ? data1_reg : '0;

endmodule

/* design/plucked_string_synth_core.sv */
// A tick word's sample passes stage 1, stage 2 and the output queue before it is offered.
// Input stalls during a word's delay-line read-modify-write and while two samples are owed.
// Plucks are paced the same way and produce no output word.
// Reset (rst_n low, asynchronous) zeroes phase, pluck state and step, sets the gain to 0.5
// and marks every delay-line entry as silent at once, so words are taken right after reset.
module plucked_string_synth_core
    import pss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic signed [SAMPLE_BITS-1:0] noise_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    // Configuration registers.
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [GAIN_BITS-1:0]  decay_gain_reg;

    // Voice state held in flip-flops; the delay line itself lives in the RAM.
    logic [PHASE_BITS-1:0]       phase_reg;
    logic signed [SAMPLE_BITS:0] pluck_sum_reg;
    line_addr_t                  pluck_pos_reg;

    // Pacing and output credit. An accepted word blocks the next cycle, which
    // keeps the delay-line write of one word clear of the reads of the next.
    logic       busy_reg;
    logic [1:0] pend_reg;

    // Stage 1: delay-line read data arrives, write-back is formed.
    logic                 s1_tick_reg;
    logic                 s1_last_reg;
    logic                 s1_change_reg;
    line_addr_t           s1_addr_reg;
    logic [FRAC_BITS-1:0] s1_frac_reg;
    sample_t              s1_last_val_reg;

    // Stage 2: the interpolation product is added to the left sample.
    logic                                   s2_valid_reg;
    sample_t                                s2_y0_reg;
    logic signed [FRAC_BITS+SAMPLE_BITS+1:0] s2_prod_reg;

    // Two-word output queue.
    sample_t    fifo_reg [2];
    logic       fifo_wr_ptr_reg;
    logic       fifo_rd_ptr_reg;
    logic [1:0] fifo_cnt_reg;

    logic in_accept;
    logic tick_accept;
    logic pluck_accept;
    logic out_pop;

    assign in_stall     = busy_reg || (pend_reg == 2'd2);
    assign in_accept    = in_valid && !in_stall;
    assign tick_accept  = in_accept && (opcode == OP_TICK);
    assign pluck_accept = in_accept && (opcode == OP_PLUCK);
    assign out_valid    = (fifo_cnt_reg != 2'd0);
    assign out_pop      = out_valid && !out_stall;
    assign sample       = fifo_reg[fifo_rd_ptr_reg];

    // Phase step and read addresses of a tick.
    line_addr_t            x0;
    line_addr_t            x1;
    logic [PHASE_BITS-1:0] phase_sum;

    assign x0        = phase_reg[PHASE_BITS-1 -: DELAY_BITS];
    assign x1        = x0 + line_addr_t'(1);
    assign phase_sum = phase_reg + phase_step_reg;

    // Pluck: the noise value is flipped when the running sum would leave the
    // unit range; after the next-to-last entry the last one cancels the sum.
    logic signed [SUM_BITS-1:0]    pluck_trial;
    logic signed [SUM_BITS-1:0]    noise_neg;
    sample_t                       pluck_val;
    logic signed [SUM_BITS-1:0]    pluck_new_sum;
    logic signed [SUM_BITS-1:0]    pluck_last_neg;
    line_addr_t                    pluck_pos_next;
    logic                          pluck_last;

    always_comb
    begin
        pluck_trial = SUM_BITS'(pluck_sum_reg) + SUM_BITS'(noise_value);
        noise_neg   = -SUM_BITS'(noise_value);
        if ((pluck_trial > WIDE_ONE) || (pluck_trial < -WIDE_ONE))
        begin
            pluck_val = sat_sample(noise_neg);
        end
        else
        begin
            pluck_val = noise_value;
        end
        pluck_new_sum  = SUM_BITS'(pluck_sum_reg) + SUM_BITS'(pluck_val);
        pluck_last_neg = -pluck_new_sum;
        pluck_pos_next = pluck_pos_reg + line_addr_t'(1);
        pluck_last     = (pluck_pos_next == LAST_ADDR);
    end

    // Delay-line RAM.
    sample_t  y0;
    sample_t  y1;
    line_wr_t line_wr;

    pss_line_ram u_line_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr0 (x0),
        .rd_addr1 (x1),
        .wr       (line_wr),
        .rd_data0 (y0),
        .rd_data1 (y1)
    );

    // Stage 1 arithmetic: the low-pass write-back and the interpolation product.
    logic signed [SAMPLE_BITS:0]              y_sum;
    logic signed [SAMPLE_BITS:0]              y_diff;
    logic signed [GAIN_BITS+SAMPLE_BITS+1:0]  filt_prod;
    sample_t                                  filt_val;
    logic signed [FRAC_BITS+SAMPLE_BITS+1:0]  interp_prod;

    always_comb
    begin
        y_sum       = (SAMPLE_BITS+1)'(y0) + (SAMPLE_BITS+1)'(y1);
        y_diff      = (SAMPLE_BITS+1)'(y1) - (SAMPLE_BITS+1)'(y0);
        filt_prod   = $signed({1'b0, decay_gain_reg}) * y_sum;
        filt_val    = sat_sample(filt_prod[GAIN_BITS +: SUM_BITS]);
        interp_prod = $signed({1'b0, s1_frac_reg}) * y_diff;
    end

    // One write port serves three sources. They never meet in one cycle: a
    // tick write-back and a final pluck entry fall in the blocked cycle after
    // their own acceptance, and a pluck's own entry at its acceptance.
    always_comb
    begin
        line_wr = '0;
        if (s1_tick_reg && s1_change_reg)
        begin
            line_wr.en   = 1'b1;
            line_wr.addr = s1_addr_reg;
            line_wr.data = filt_val;
        end
        else if (s1_last_reg)
        begin
            line_wr.en   = 1'b1;
            line_wr.addr = LAST_ADDR;
            line_wr.data = s1_last_val_reg;
        end
        else if (pluck_accept)
        begin
            line_wr.en   = 1'b1;
            line_wr.addr = pluck_pos_reg;
            line_wr.data = pluck_val;
        end
    end

    // Stage 2: the floor-shifted product stays within the step between the
    // two samples, so the sum fits the sample width.
    logic signed [SAMPLE_BITS:0] out_wide;
    assign out_wide = (SAMPLE_BITS+1)'(s2_y0_reg) + s2_prod_reg[FRAC_BITS +: SAMPLE_BITS+1];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            decay_gain_reg <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                REG_DECAY_GAIN: decay_gain_reg <= cfg_data[GAIN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Control state.
    logic [1:0] pend_next;
    always_comb
    begin
        pend_next = pend_reg + {1'b0, tick_accept} - {1'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            pluck_sum_reg   <= '0;
            pluck_pos_reg   <= '0;
            busy_reg        <= 1'b0;
            pend_reg        <= 2'd0;
            s1_tick_reg     <= 1'b0;
            s1_last_reg     <= 1'b0;
            s2_valid_reg    <= 1'b0;
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
            fifo_cnt_reg    <= 2'd0;
        end
        else
        begin
            busy_reg     <= in_accept;
            pend_reg     <= pend_next;
            s1_tick_reg  <= tick_accept;
            s1_last_reg  <= pluck_accept && pluck_last;
            s2_valid_reg <= s1_tick_reg;

            if (tick_accept)
            begin
                phase_reg <= phase_sum;
            end

            if (pluck_accept)
            begin
                if (pluck_last)
                begin
                    pluck_sum_reg <= '0;
                    pluck_pos_reg <= '0;
                end
                else
                begin
                    pluck_sum_reg <= pluck_new_sum[SAMPLE_BITS:0];
                    pluck_pos_reg <= pluck_pos_next;
                end
            end

            if (s2_valid_reg)
            begin
                fifo_wr_ptr_reg <= !fifo_wr_ptr_reg;
            end
            if (out_pop)
            begin
                fifo_rd_ptr_reg <= !fifo_rd_ptr_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, s2_valid_reg} - {1'b0, out_pop};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg     <= x0;
            s1_frac_reg     <= phase_reg[FRAC_BITS-1:0];
            s1_change_reg   <= (phase_sum[PHASE_BITS-1 -: DELAY_BITS] != x0);
            s1_last_val_reg <= sat_sample(pluck_last_neg);
        end
        if (s1_tick_reg)
        begin
            s2_y0_reg   <= y0;
            s2_prod_reg <= interp_prod;
        end
        if (s2_valid_reg)
        begin
            fifo_reg[fifo_wr_ptr_reg] <= out_wide[SAMPLE_BITS-1:0];
        end
    end

endmodule

/* design/pss_checker.sv */
`include "plucked_string_synth_core_defines.svh"

module pss_checker
    import pss_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          opcode,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample
);

    logic in_acc;
    logic tick_acc;

    assign in_acc   = in_valid && !in_stall;
    assign tick_acc = in_acc && (opcode == OP_TICK);

    // A held output word keeps its value.
    `PSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample))

    // The core never takes words on two consecutive edges.
    `PSS_ASSERT_NEXT(a_paced, in_acc, in_stall)

    // Every tick word is answered on the output once it has passed both pipeline stages.
    `PSS_ASSERT_NOW(a_tick_answer, tick_acc, ##3 out_valid)

endmodule

bind plucked_string_synth_core pss_checker u_pss_checker (.*);

/* sim/tb_plucked_string_synth_core.sv */
`timescale 1ns / 100ps

module tb_plucked_string_synth_core;

    import pss_pkg::*;

    // Index of the highest register slot; every slot above the decay gain is unused.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST = '1;

    // The value 1.0 of the sample format, which the excitation sum may just reach.
    localparam longint FULL_SCALE = -longint'(S_MIN);

    // One row of the directed part: either a register write or an input word.
    typedef enum logic
    {
        ROW_WRITE_REG,
        ROW_WORD
    } row_kind_e;

    typedef struct
    {
        row_kind_e                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_data;
        logic                      op;
        sample_t                   noise;
        bit                        typed;
        sample_t                   typed_sample;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] noise_value;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] sample;

    // Our own copy of the string state, advanced once per accepted input word.
    logic [PHASE_BITS-1:0]         acc_phase;
    logic [PHASE_BITS-1:0]         cur_step;
    logic [GAIN_BITS-1:0]          cur_gain;
    sample_t                       line_mem [LINE_SIZE];
    longint                        excite_sum;
    line_addr_t                    excite_pos;

    // Samples that the block still owes us, oldest first.
    sample_t                       expected_samples [$];
    stim_row_t                     stim_rows [$];
    int                            mismatch_count;
    int                            results_seen;

    plucked_string_synth_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .noise_value (noise_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run. A correct run ends far earlier, even with every
    // gap and stall at its longest.
    initial
    begin
        #10_000_000;
        $display("[plucked_string_synth_core] ERROR");
        $finish;
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic sample_t clip_sample(input longint v);
        if (v > longint'(S_MAX))
        begin
            return S_MAX;
        end
        if (v < longint'(S_MIN))
        begin
            return S_MIN;
        end
        return sample_t'(v);
    endfunction

    task automatic reset_string_model();
        acc_phase  = '0;
        cur_step   = '0;
        cur_gain   = GAIN_RESET;
        excite_sum = 0;
        excite_pos = '0;
        for (int i = 0; i < LINE_SIZE; i++)
        begin
            line_mem[i] = '0;
        end
    endtask

    // Advances the string by one word. A tick returns 1 with the interpolated
    // sample; a pluck writes one excitation value and returns 0.
    function automatic bit advance_string(input logic op, input sample_t noise,
                                          output sample_t y_out);
        line_addr_t i0;
        line_addr_t i1;
        longint     y0;
        longint     y1;
        longint     frac;
        longint     v;
        y_out = '0;
        if (op == OP_TICK)
        begin
            i0   = line_addr_t'(acc_phase >> FRAC_BITS);
            i1   = i0 + 1'b1;
            y0   = line_mem[i0];
            y1   = line_mem[i1];
            frac = longint'(acc_phase[FRAC_BITS-1:0]);
            // The arithmetic shift of a signed value rounds toward minus infinity.
            y_out = sample_t'(y0 + (((y1 - y0) * frac) >>> FRAC_BITS));
            acc_phase = acc_phase + cur_step;
            if (line_addr_t'(acc_phase >> FRAC_BITS) != i0)
            begin
                line_mem[i0] = clip_sample((longint'(cur_gain) * (y0 + y1)) >>> GAIN_BITS);
            end
            return 1'b1;
        end
        v = noise;
        // Keep the running sum within plus or minus one by flipping the sign.
        if (excite_sum + v > FULL_SCALE || excite_sum + v < -FULL_SCALE)
        begin
            v = clip_sample(-v);
        end
        excite_sum = excite_sum + v;
        line_mem[excite_pos] = sample_t'(v);
        excite_pos = excite_pos + 1'b1;
        if (excite_pos == LAST_ADDR)
        begin
            // The last entry cancels the sum so the excitation has no offset.
            line_mem[LAST_ADDR] = clip_sample(-excite_sum);
            excite_sum = 0;
            excite_pos = '0;
        end
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(2, 1);
        end
        if (r < 97)
        begin
            return $urandom_range(8, 3);
        end
        return $urandom_range(40, 12);
    endfunction

    function automatic sample_t pick_noise();
        case ($urandom_range(15, 0))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Steers the end of an excitation run so that the sum lands on exactly
    // minus one, which makes the closing entry saturate at the positive end.
    function automatic sample_t aimed_noise();
        if (excite_pos == LAST_ADDR - 2)
        begin
            return clip_sample(-excite_sum);
        end
        if (excite_pos == LAST_ADDR - 1 && excite_sum <= 0)
        begin
            return sample_t'(-FULL_SCALE - excite_sum);
        end
        return pick_noise();
    endfunction

    // Offers one word from a falling edge, holds it until the block takes it,
    // then leaves a random gap. Returns at a falling edge.
    task automatic send_word(input logic op, input sample_t noise, input bit typed,
                             input sample_t typed_sample);
        sample_t predicted;
        int      gap;
        in_valid    = 1'b1;
        opcode      = op;
        noise_value = noise;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (advance_string(op, noise, predicted))
        begin
            expected_samples.push_back(typed ? typed_sample : predicted);
        end
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Brings the block to rest before a register write. A pluck gives no
    // sample, so the wait goes on past the last sample to cover one still in flight.
    task automatic settle_block();
        in_valid = 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        if (index == REG_PHASE_STEP)
        begin
            cur_step = data;
        end
        else if (index == REG_DECAY_GAIN)
        begin
            cur_gain = data[GAIN_BITS-1:0];
        end
    endtask

    task automatic add_word(input logic op, input sample_t noise, input bit typed,
                            input sample_t typed_sample);
        stim_row_t row;
        row.kind         = ROW_WORD;
        row.reg_index    = REG_PHASE_STEP;
        row.reg_data     = '0;
        row.op           = op;
        row.noise        = noise;
        row.typed        = typed;
        row.typed_sample = typed_sample;
        stim_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t row;
        row.kind         = ROW_WRITE_REG;
        row.reg_index    = index;
        row.reg_data     = data;
        row.op           = OP_TICK;
        row.noise        = '0;
        row.typed        = 1'b0;
        row.typed_sample = '0;
        stim_rows.push_back(row);
    endtask

    // Output side: every sample taken from the block is checked against the
    // oldest one still owed.
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_samples.size() == 0)
            begin
                flag_error($sformatf("sample %0d arrived with none expected", sample));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample !== want)
                begin
                    flag_error($sformatf("sample is %0d, expected %0d", sample, want));
                end
            end
        end
    end

    // Receiver: runs of ready cycles broken by stalls of random length. Once,
    // well into the run, it holds off for a long stretch while words keep
    // coming, so the block fills up and has to stall its own input.
    initial
    begin
        int  hold;
        bit  pressure_done;
        pressure_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            out_stall = 1'b0;
            repeat ($urandom_range(24, 1)) @(negedge clk);
            if (!pressure_done && results_seen >= 150)
            begin
                pressure_done = 1'b1;
                hold = 80;
            end
            else
            begin
                hold = pick_gap();
            end
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    initial
    begin
        int      plucks_left;
        int      waited;
        bit      aim;
        sample_t noise;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_PHASE_STEP;
        cfg_data       = '0;
        in_valid       = 1'b0;
        opcode         = OP_TICK;
        noise_value    = '0;
        mismatch_count = 0;
        results_seen   = 0;
        reset_string_model();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A silent line gives zero; after the first five plucks
        // the entries are known, and with a whole-entry step and no fraction
        // each tick returns one of them unchanged. The plucks cover both
        // extremes, the sign flip when the sum would pass one, and the flip of
        // the most negative value, which has to saturate.
        add_word(OP_TICK, '0, 1'b1, '0);
        add_word(OP_TICK, S_MIN, 1'b1, '0);
        add_reg(REG_PHASE_STEP, 32'h0100_0000);
        add_word(OP_PLUCK, S_MAX, 1'b0, '0);
        add_word(OP_PLUCK, S_MAX, 1'b0, '0);
        add_word(OP_PLUCK, S_MIN, 1'b0, '0);
        add_word(OP_PLUCK, S_MIN, 1'b0, '0);
        add_word(OP_PLUCK, '0, 1'b0, '0);
        add_word(OP_TICK, '0, 1'b1, S_MAX);
        add_word(OP_TICK, '0, 1'b1, -S_MAX);
        add_word(OP_TICK, '0, 1'b1, S_MIN);
        add_word(OP_TICK, '0, 1'b1, S_MAX);
        // Full gain with junk above the register width, and a write to an
        // unused slot that must change nothing.
        add_reg(REG_DECAY_GAIN, 32'hA5A5_FFFF);
        add_reg(REG_SPARE_LAST, 32'h5A5A_5A5A);
        // Half-entry steps give real interpolation; plucks between ticks carry
        // on the excitation run where it stopped.
        add_reg(REG_PHASE_STEP, 32'h0080_0000);
        add_word(OP_TICK, '0, 1'b0, '0);
        add_word(OP_PLUCK, -16'sd1234, 1'b0, '0);
        add_word(OP_TICK, '0, 1'b0, '0);
        add_word(OP_TICK, '0, 1'b0, '0);
        // The largest step wraps to minus one phase unit, walking the line backwards by the smallest amount per tick.
        add_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        add_word(OP_TICK, '0, 1'b0, '0);
        add_word(OP_TICK, '0, 1'b0, '0);
        add_word(OP_PLUCK, 16'sd12345, 1'b0, '0);
        add_word(OP_TICK, '0, 1'b0, '0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_WRITE_REG)
            begin
                settle_block();
                write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
            end
            else
            begin
                send_word(stim_rows[i].op, stim_rows[i].noise, stim_rows[i].typed,
                          stim_rows[i].typed_sample);
            end
        end

        // Random part, in phases with their own settings. Most phases finish an
        // excitation run with random content and ticks sprinkled in, then let
        // the string ring; one leaves a run unfinished, the last is a free mix.
        for (int ph = 0; ph < 5; ph++)
        begin
            settle_block();
            case (ph)
                0:
                begin
                    write_reg(REG_PHASE_STEP, $urandom_range(32'h0200_0000, 32'h0040_0000));
                    write_reg(REG_DECAY_GAIN, {16'($urandom), 16'hFFFF});
                end
                1:
                begin
                    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
                    write_reg(REG_DECAY_GAIN, {16'($urandom), 16'h0000});
                end
                2:
                begin
                    write_reg(REG_PHASE_STEP, '0);
                    write_reg(REG_DECAY_GAIN, $urandom);
                    write_reg(CFG_INDEX_BITS'($urandom_range(int'(REG_SPARE_LAST),
                                                             int'(REG_DECAY_GAIN) + 1)),
                              $urandom);
                end
                3:
                begin
                    write_reg(REG_PHASE_STEP, $urandom_range(32'h0400_0000, 32'h0001_0000));
                    write_reg(REG_DECAY_GAIN, $urandom);
                end
                default:
                begin
                    write_reg(REG_PHASE_STEP, $urandom);
                    write_reg(REG_DECAY_GAIN, {16'($urandom), GAIN_RESET});
                end
            endcase

            if (ph == 4)
            begin
                repeat (150)
                begin
                    send_word($urandom_range(1, 0) ? OP_PLUCK : OP_TICK, pick_noise(),
                              1'b0, '0);
                end
            end
            else
            begin
                if (ph == 2)
                begin
                    plucks_left = $urandom_range(120, 30);
                end
                else
                begin
                    plucks_left = int'(LAST_ADDR) - int'(excite_pos);
                end
                aim = (ph != 2);
                while (plucks_left > 0)
                begin
                    if ($urandom_range(7, 0) == 0)
                    begin
                        send_word(OP_TICK, pick_noise(), 1'b0, '0);
                    end
                    else
                    begin
                        noise = aim ? aimed_noise() : pick_noise();
                        send_word(OP_PLUCK, noise, 1'b0, '0);
                        plucks_left--;
                    end
                end
                repeat (40) send_word(OP_TICK, pick_noise(), 1'b0, '0);
                repeat (20)
                begin
                    send_word($urandom_range(1, 0) ? OP_PLUCK : OP_TICK, pick_noise(),
                              1'b0, '0);
                end
            end
        end

        // Drain: wait for every owed sample, with a bound, then wait further
        // so that a stray extra sample would still be caught.
        in_valid = 1'b0;
        waited = 0;
        while (expected_samples.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
        if (expected_samples.size() != 0)
        begin
            flag_error($sformatf("%0d expected samples never arrived",
                                 expected_samples.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("[plucked_string_synth_core] OK");
        end
        else
        begin
            $display("[plucked_string_synth_core] ERROR");
        end
        $finish;
    end

endmodule
